/* hdl/work_stealing_deque_unit_assert.svh */
// Assertion macros shared by the work stealing deque unit.
`ifndef WORK_STEALING_DEQUE_UNIT_ASSERT_SVH
`define WORK_STEALING_DEQUE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/wsd_pkg.sv */
// Shared constants, codes and types of the work stealing deque unit.
`timescale 1ns / 1ps

package wsd_pkg;

   // Ring depth; must be a power of two.
   localparam int DEPTH  = 4096;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int PTR_W  = SLOT_W + 1;
   localparam int FUNC_W = 2;
   localparam int DATA_W = 64;
   localparam int STAT_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUSH  = FUNC_W'(0);
   localparam logic [FUNC_W-1:0] FUNC_POP   = FUNC_W'(1);
   localparam logic [FUNC_W-1:0] FUNC_STEAL = FUNC_W'(2);

   localparam logic [STAT_W-1:0] STAT_OK    = STAT_W'(0);
   localparam logic [STAT_W-1:0] STAT_EMPTY = STAT_W'(1);
   localparam logic [STAT_W-1:0] STAT_FULL  = STAT_W'(2);

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

/* hdl/wsd_ctrl.sv */
// Controller of the work stealing deque unit: transaction sequencing and response valid.
`timescale 1ns / 1ps

module wsd_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output wsd_pkg::cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/wsd_datapath.sv */
// Datapath of the work stealing deque unit: pointers, slot memory and response register.
`timescale 1ns / 1ps

module wsd_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  wsd_pkg::cmd_type               cmd,
   input  logic [wsd_pkg::FUNC_W-1:0]     req_func,
   input  logic [wsd_pkg::DATA_W-1:0]     req_task_value,
   output logic [wsd_pkg::DATA_W-1:0]     rsp_taken_value,
   output logic [wsd_pkg::STAT_W-1:0]     rsp_status
);

   logic [wsd_pkg::DATA_W-1:0] slot_mem [wsd_pkg::DEPTH];

   logic [wsd_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [wsd_pkg::PTR_W-1:0]  tail_ff, tail_in;
   logic [wsd_pkg::PTR_W-1:0]  occ;
   logic [wsd_pkg::PTR_W-1:0]  tail_prev;
   logic [wsd_pkg::SLOT_W-1:0] rd_addr;
   logic [wsd_pkg::FUNC_W-1:0] func_ff;
   logic [wsd_pkg::DATA_W-1:0] value_ff;
   logic [wsd_pkg::DATA_W-1:0] rdata_ff;
   logic [wsd_pkg::DATA_W-1:0] taken_ff, taken_in;
   logic [wsd_pkg::STAT_W-1:0] status_ff, status_in;
   logic                       full;
   logic                       empty;
   logic                       wr_en;

   assign occ       = tail_ff - head_ff;
   assign full      = (occ == wsd_pkg::PTR_W'(wsd_pkg::DEPTH));
   assign empty     = (tail_ff == head_ff);
   assign tail_prev = tail_ff - wsd_pkg::PTR_W'(1);
   assign rd_addr   = (req_func == wsd_pkg::FUNC_POP) ? tail_prev[wsd_pkg::SLOT_W-1:0]
                                                      : head_ff[wsd_pkg::SLOT_W-1:0];

   // Vacated slots are not zeroed: only data read from the occupied range is used,
   // and every slot in it was written by a push.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      wr_en     = 1'b0;
      taken_in  = '0;
      status_in = wsd_pkg::STAT_EMPTY;
      unique case (func_ff)
         wsd_pkg::FUNC_PUSH: begin
            if (full) begin
               status_in = wsd_pkg::STAT_FULL;
            end else begin
               wr_en     = cmd.commit;
               tail_in   = cmd.commit ? tail_ff + wsd_pkg::PTR_W'(1) : tail_ff;
               status_in = wsd_pkg::STAT_OK;
            end
         end
         wsd_pkg::FUNC_POP: begin
            if (!empty) begin
               taken_in  = rdata_ff;
               tail_in   = cmd.commit ? tail_prev : tail_ff;
               status_in = wsd_pkg::STAT_OK;
            end
         end
         wsd_pkg::FUNC_STEAL: begin
            if (!empty && (rdata_ff != '0)) begin
               taken_in  = rdata_ff;
               head_in   = cmd.commit ? head_ff + wsd_pkg::PTR_W'(1) : head_ff;
               status_in = wsd_pkg::STAT_OK;
            end
         end
         default: status_in = wsd_pkg::STAT_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_task_value;
      end
      if (cmd.commit) begin
         taken_ff  <= taken_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[tail_ff[wsd_pkg::SLOT_W-1:0]] <= value_ff;
      end
      if (cmd.capture) begin
         rdata_ff <= slot_mem[rd_addr];
      end
   end

   assign rsp_taken_value = taken_ff;
   assign rsp_status      = status_ff;

endmodule

/* hdl/work_stealing_deque_unit.sv */
// Top level of the work stealing deque unit.
// A request is captured on acceptance; its result is committed to the response register
// from the execute state, and no new request is taken before that commit. The registered
// slot memory read lies between them; commit waits while the response register is stalled.
// Reset clears head, tail and control state at once; the slot memory needs no clearing pass.
`timescale 1ns / 1ps
`include "work_stealing_deque_unit_assert.svh"

module work_stealing_deque_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [wsd_pkg::FUNC_W-1:0] req_func,
   input  logic [wsd_pkg::DATA_W-1:0] req_task_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [wsd_pkg::DATA_W-1:0] rsp_taken_value,
   output logic [wsd_pkg::STAT_W-1:0] rsp_status
);

   wsd_pkg::cmd_type cmd;
   logic             rsp_failed;

   wsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   wsd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_task_value  (req_task_value),
      .rsp_taken_value (rsp_taken_value),
      .rsp_status      (rsp_status)
   );

   assign rsp_failed = rsp_valid && (rsp_status != wsd_pkg::STAT_OK);

   `WSD_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted while busy")
   `WSD_ASSERT_NOW(a_commit_no_overwrite, cmd.commit, !(rsp_valid && rsp_stall), "response lost")
   `WSD_ASSERT_NOW(a_fail_zero, rsp_failed, rsp_taken_value == '0, "handle returned on failure")

endmodule

/* tb/wsd_checker.sv */
// Scoreboard for the work stealing deque unit: models the ring and checks each response.
`timescale 1ns / 1ps

module wsd_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [wsd_pkg::FUNC_W-1:0] req_func,
   input  logic [wsd_pkg::DATA_W-1:0] req_task_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [wsd_pkg::DATA_W-1:0] rsp_taken_value,
   input  logic [wsd_pkg::STAT_W-1:0] rsp_status,
   output int                         mismatch_count,
   output int                         outstanding_count,
   output int                         response_count,
   output int                         taken_count,
   output int                         refused_push_count,
   output int                         blocked_take_count
);

   typedef struct packed {
      logic [wsd_pkg::DATA_W-1:0] taken;
      logic [wsd_pkg::STAT_W-1:0] status;
   } deque_result_type;

   logic [wsd_pkg::DATA_W-1:0] ring_slots [wsd_pkg::DEPTH];
   logic [wsd_pkg::PTR_W-1:0]  head_ptr;
   logic [wsd_pkg::PTR_W-1:0]  tail_ptr;
   deque_result_type           pending_results [$];

   int errors    = 0;
   int responses = 0;
   int takes     = 0;
   int refusals  = 0;
   int blocked   = 0;

   // Pointers run modulo twice the depth; the low bits address the slot.
   function automatic deque_result_type apply_deque_op(
         input logic [wsd_pkg::FUNC_W-1:0] op,
         input logic [wsd_pkg::DATA_W-1:0] handle);
      deque_result_type          res;
      logic [wsd_pkg::PTR_W-1:0] fill;
      logic [wsd_pkg::PTR_W-1:0] prev;
      res.taken  = '0;
      res.status = wsd_pkg::STAT_EMPTY;
      fill       = tail_ptr - head_ptr;
      case (op)
         wsd_pkg::FUNC_PUSH: begin
            if (fill == wsd_pkg::PTR_W'(wsd_pkg::DEPTH)) begin
               res.status = wsd_pkg::STAT_FULL;
            end else begin
               ring_slots[tail_ptr[wsd_pkg::SLOT_W-1:0]] = handle;
               tail_ptr   = tail_ptr + wsd_pkg::PTR_W'(1);
               res.status = wsd_pkg::STAT_OK;
            end
         end
         wsd_pkg::FUNC_POP: begin
            if (fill != '0) begin
               prev       = tail_ptr - wsd_pkg::PTR_W'(1);
               res.taken  = ring_slots[prev[wsd_pkg::SLOT_W-1:0]];
               ring_slots[prev[wsd_pkg::SLOT_W-1:0]] = '0;
               tail_ptr   = prev;
               res.status = wsd_pkg::STAT_OK;
            end
         end
         wsd_pkg::FUNC_STEAL: begin
            if (fill != '0 && ring_slots[head_ptr[wsd_pkg::SLOT_W-1:0]] != '0) begin
               res.taken  = ring_slots[head_ptr[wsd_pkg::SLOT_W-1:0]];
               ring_slots[head_ptr[wsd_pkg::SLOT_W-1:0]] = '0;
               head_ptr   = head_ptr + wsd_pkg::PTR_W'(1);
               res.status = wsd_pkg::STAT_OK;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // A successful push carries zero; nonzero data on success means a removal.
   function automatic logic req_func_was_take(input deque_result_type r);
      return r.taken != '0;
   endfunction

   always @(posedge clock) begin
      deque_result_type want;
      if (reset) begin
         for (int i = 0; i < wsd_pkg::DEPTH; i++) ring_slots[i] = '0;
         head_ptr = '0;
         tail_ptr = '0;
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses++;
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected response transaction: taken_value %h status %0d",
                        $time, rsp_taken_value, rsp_status);
            end else begin
               want = pending_results.pop_front();
               if (rsp_taken_value !== want.taken) begin
                  errors++;
                  $display("%0t: taken_value mismatch: expected %h, actual %h",
                           $time, want.taken, rsp_taken_value);
               end
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (want.status == wsd_pkg::STAT_FULL) refusals++;
               else if (want.status == wsd_pkg::STAT_EMPTY) blocked++;
               else if (want.status == wsd_pkg::STAT_OK && req_func_was_take(want)) takes++;
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(apply_deque_op(req_func, req_task_value));
         end
      end
      mismatch_count     <= errors;
      outstanding_count  <= pending_results.size();
      response_count     <= responses;
      taken_count        <= takes;
      refused_push_count <= refusals;
      blocked_take_count <= blocked;
   end

endmodule

/* tb/testbench.sv */
// Top of the work stealing deque unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam logic [wsd_pkg::FUNC_W-1:0] FUNC_NONE   = wsd_pkg::FUNC_W'(3);
   localparam int                         CYCLE_LIMIT = 400000;
   localparam int                         PHASE_ITEMS = 470;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [wsd_pkg::FUNC_W-1:0] req_func       = wsd_pkg::FUNC_PUSH;
   logic [wsd_pkg::DATA_W-1:0] req_task_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic [wsd_pkg::DATA_W-1:0] rsp_taken_value;
   logic [wsd_pkg::STAT_W-1:0] rsp_status;

   int mismatch_count;
   int outstanding_count;
   int response_count;
   int taken_count;
   int refused_push_count;
   int blocked_take_count;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int cycle_count   = 0;

   int phase_idle [4]  = '{0, 86, 0, 15};
   int phase_stall [4] = '{0, 0, 86, 15};

   work_stealing_deque_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_task_value  (req_task_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_taken_value (rsp_taken_value),
      .rsp_status      (rsp_status)
   );

   wsd_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_task_value     (req_task_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_taken_value    (rsp_taken_value),
      .rsp_status         (rsp_status),
      .mismatch_count     (mismatch_count),
      .outstanding_count  (outstanding_count),
      .response_count     (response_count),
      .taken_count        (taken_count),
      .refused_push_count (refused_push_count),
      .blocked_take_count (blocked_take_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [wsd_pkg::DATA_W-1:0] random_handle();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 12) return '1;
      return {$urandom, $urandom};
   endfunction

   // Returns at the edge where the transaction is accepted.
   task automatic send_item(input logic [wsd_pkg::FUNC_W-1:0] op,
                            input logic [wsd_pkg::DATA_W-1:0] handle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= op;
      req_task_value <= handle;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int                         roll;
      logic                       draining;
      logic [wsd_pkg::FUNC_W-1:0] op;
      draining = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases
      send_item(wsd_pkg::FUNC_POP, '1);
      send_item(wsd_pkg::FUNC_STEAL, '1);
      send_item(FUNC_NONE, 64'h0123_4567_89ab_cdef);
      send_item(wsd_pkg::FUNC_PUSH, '0);
      send_item(wsd_pkg::FUNC_STEAL, '0);
      send_item(wsd_pkg::FUNC_POP, '0);
      send_item(wsd_pkg::FUNC_PUSH, '1);
      send_item(wsd_pkg::FUNC_PUSH, 64'h1);
      send_item(wsd_pkg::FUNC_PUSH, 64'h8000_0000_0000_0000);
      send_item(wsd_pkg::FUNC_STEAL, '0);
      send_item(wsd_pkg::FUNC_POP, '0);
      send_item(wsd_pkg::FUNC_STEAL, '0);
      send_item(wsd_pkg::FUNC_STEAL, '0);
      send_item(wsd_pkg::FUNC_PUSH, 64'h0123_4567_89ab_cdef);
      send_item(wsd_pkg::FUNC_PUSH, '0);
      send_item(wsd_pkg::FUNC_STEAL, '0);
      send_item(wsd_pkg::FUNC_STEAL, '0);
      send_item(wsd_pkg::FUNC_POP, '0);
      send_item(wsd_pkg::FUNC_POP, '0);
      send_item(FUNC_NONE, '1);

      // random mix in bursts that lean towards filling or draining
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_idle[p];
         stall_pct     = phase_stall[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0) draining = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (roll < 5) op = FUNC_NONE;
            else if (roll < (draining ? 25 : 60)) op = wsd_pkg::FUNC_PUSH;
            else if (roll < (draining ? 60 : 78)) op = wsd_pkg::FUNC_POP;
            else op = wsd_pkg::FUNC_STEAL;
            send_item(op, random_handle());
         end
      end

      req_valid <= 1'b0;
      stall_pct = 0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Checked %0d responses: %0d handles removed, %0d pushes refused on a full ring,",
               response_count, taken_count, refused_push_count);
      $display("%0d pops, steals or unused codes answered as empty or blocked.",
               blocked_take_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* work_stealing_deque_unit.f */
+incdir+hdl
hdl/wsd_pkg.sv
hdl/wsd_ctrl.sv
hdl/wsd_datapath.sv
hdl/work_stealing_deque_unit.sv
tb/wsd_checker.sv
tb/testbench.sv
